FILE: hw/rtl/dhte_pkg.sv
// ----------------------------------------------------------------------------
// dhte_pkg
// Shared types, codes and hash functions of the double hash table engine.
// ----------------------------------------------------------------------------
package dhte_pkg;

  // Table geometry: the size must be a power of two
  localparam int TABLE_SIZE = 1024;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

  // Word field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 31;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 11;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_ABSENT  = 2'd1,
    STATUS_DELETED = 2'd2,
    STATUS_FULL    = 2'd3
  } status_e;

  // One table slot as stored in memory
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic               used;
    logic               filled;
  } slot_t;

  // Home slot: key * (size - 1) mod size
  function automatic idx_t home_slot(key_t k);
    logic [2*IDX_W-1:0] p;
    p = (2*IDX_W)'(k[IDX_W-1:0]) * (2*IDX_W)'(TABLE_SIZE - 1);
    return p[IDX_W-1:0];
  endfunction

  // Probe step: key * (size - 3) mod size, forced odd
  function automatic idx_t probe_step(key_t k);
    logic [2*IDX_W-1:0] p;
    p = (2*IDX_W)'(k[IDX_W-1:0]) * (2*IDX_W)'(TABLE_SIZE - 3);
    return p[IDX_W-1:0] | idx_t'(1);
  endfunction

endpackage

FILE: hw/rtl/dhte_ram.sv
// ----------------------------------------------------------------------------
// dhte_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is enabled.
// ----------------------------------------------------------------------------
module dhte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/double_hash_table_engine_top.sv
// ----------------------------------------------------------------------------
// double_hash_table_engine_top
// Open-addressing key/value table with double hashing, kept in one slot RAM.
// ----------------------------------------------------------------------------
// After reset the engine sweeps the slot RAM once to clear it; no word is
// taken during the sweep. An item then visits P slots along its probe path,
// where P is 1 to 1024: one slot RAM read per cycle, with the next probe
// address issued while the current slot is checked. One item is in work at
// a time; a finished result waits in the output register while the next
// word is accepted.
// ----------------------------------------------------------------------------
module double_hash_table_engine_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [dhte_pkg::OP_W-1:0]        operation_i,
  input  logic [dhte_pkg::KEY_W-1:0]       key_i,
  input  logic signed [dhte_pkg::VALUE_W-1:0] value_i,
  // Result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [dhte_pkg::VALUE_W-1:0] found_value_o,
  output logic [dhte_pkg::STATUS_W-1:0]    status_o,
  output logic [dhte_pkg::FILL_W-1:0]      fill_count_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK
  } state_e;

  state_e                              state_q;
  dhte_pkg::idx_t                      clr_q;
  dhte_pkg::idx_t                      idx_q;
  dhte_pkg::idx_t                      step_q;
  dhte_pkg::cnt_t                      probes_q;
  dhte_pkg::cnt_t                      filled_q;
  dhte_pkg::cnt_t                      filled_d;
  dhte_pkg::op_e                       op_q;
  dhte_pkg::key_t                      key_q;
  logic [dhte_pkg::VALUE_W-1:0]        value_q;

  logic                                out_valid_q;
  logic [dhte_pkg::VALUE_W-1:0]        found_q;
  logic [dhte_pkg::VALUE_W-1:0]        found_d;
  dhte_pkg::status_e                   status_q;
  dhte_pkg::status_e                   status_d;

  logic                                accept;
  logic                                out_free;
  logic                                stop;
  logic                                fail;
  logic                                finish;
  logic                                slot_wr;
  dhte_pkg::slot_t                     slot_new;
  dhte_pkg::slot_t                     rd_slot;

  logic                                ram_we;
  dhte_pkg::idx_t                      ram_waddr;
  logic [$bits(dhte_pkg::slot_t)-1:0]  ram_wdata;
  logic                                ram_re;
  dhte_pkg::idx_t                      ram_raddr;
  logic [$bits(dhte_pkg::slot_t)-1:0]  ram_rdata;

  // Handshake
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign rd_slot = dhte_pkg::slot_t'(ram_rdata);

  // Check the slot just read and decide the outcome
  always_comb begin
    stop     = 1'b0;
    slot_wr  = 1'b0;
    slot_new = rd_slot;
    found_d  = '0;
    status_d = dhte_pkg::STATUS_ABSENT;
    filled_d = filled_q;
    unique case (op_q)
      dhte_pkg::OP_INSERT: begin
        stop = !rd_slot.filled;
        if (stop) begin
          slot_wr         = 1'b1;
          slot_new.key    = key_q;
          slot_new.value  = value_q;
          slot_new.used   = 1'b1;
          slot_new.filled = 1'b1;
          status_d        = dhte_pkg::STATUS_OK;
          filled_d        = filled_q + dhte_pkg::cnt_t'(1);
        end
      end
      dhte_pkg::OP_LOOKUP, dhte_pkg::OP_REMOVE: begin
        stop = !rd_slot.used || (rd_slot.key == key_q);
        if (stop && rd_slot.used && rd_slot.filled) begin
          found_d  = rd_slot.value;
          status_d = dhte_pkg::STATUS_OK;
          if (op_q == dhte_pkg::OP_REMOVE) begin
            slot_wr         = 1'b1;
            slot_new.filled = 1'b0;
            if (filled_q != '0) begin
              filled_d = filled_q - dhte_pkg::cnt_t'(1);
            end
          end
        end else if (stop && rd_slot.used) begin
          status_d = dhte_pkg::STATUS_DELETED;
        end
      end
      default: begin
        stop = 1'b1;
      end
    endcase
    fail = !stop && (probes_q == dhte_pkg::cnt_t'(dhte_pkg::TABLE_SIZE));
    if (fail && op_q == dhte_pkg::OP_INSERT) begin
      status_d = dhte_pkg::STATUS_FULL;
    end
  end

  assign finish = (state_q == S_CHECK) && (stop || fail) && out_free;

  // Slot RAM ports: clear sweep, write-back on finish, read on accept or advance
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = slot_new;
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (finish && slot_wr && !fail) begin
      ram_we = 1'b1;
    end
    ram_re    = 1'b0;
    ram_raddr = idx_q + step_q;
    if (accept) begin
      ram_re    = 1'b1;
      ram_raddr = dhte_pkg::home_slot(key_i);
    end else if (state_q == S_CHECK && !stop && !fail) begin
      ram_re = 1'b1;
    end
  end

  dhte_ram #(
    .WIDTH ($bits(dhte_pkg::slot_t)),
    .DEPTH (dhte_pkg::TABLE_SIZE)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer, fill count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      probes_q    <= '0;
      filled_q    <= '0;
      op_q        <= dhte_pkg::OP_INSERT;
      key_q       <= '0;
      value_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= '0;
      status_q    <= dhte_pkg::STATUS_OK;
    end else begin
      // drop a result once taken, unless the next one replaces it
      if (out_valid_q && !out_stall_i && !finish) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + dhte_pkg::idx_t'(1);
          if (clr_q == dhte_pkg::idx_t'(dhte_pkg::TABLE_SIZE - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q     <= dhte_pkg::op_e'(operation_i);
            key_q    <= key_i;
            value_q  <= value_i;
            idx_q    <= dhte_pkg::home_slot(key_i);
            step_q   <= dhte_pkg::probe_step(key_i);
            probes_q <= dhte_pkg::cnt_t'(1);
            state_q  <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (finish) begin
            out_valid_q <= 1'b1;
            found_q     <= found_d;
            status_q    <= status_d;
            if (!fail) begin
              filled_q <= filled_d;
            end
            state_q <= S_IDLE;
          end else if (!stop && !fail) begin
            // advance along the probe path
            idx_q    <= idx_q + step_q;
            probes_q <= probes_q + dhte_pkg::cnt_t'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_value_o = found_q;
  assign status_o      = status_q;
  assign fill_count_o  = dhte_pkg::FILL_W'(filled_q);

  // Fill count never exceeds the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= dhte_pkg::cnt_t'(dhte_pkg::TABLE_SIZE))
    else $error("fill count above table size");

  // Fill count only moves when an item finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !finish |=> $stable(filled_q))
    else $error("fill count changed without a finished item");

  // A result appears only right after a probe finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(finish))
    else $error("result raised without a finished probe");

  // Probe count stays within the table while searching
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (probes_q != '0 &&
      probes_q <= dhte_pkg::cnt_t'(dhte_pkg::TABLE_SIZE)))
    else $error("probe count out of range");

endmodule
